// ===== sv/psm_pkg.sv =====
`default_nettype none

package psm_pkg;

    // Accumulator format: unsigned Q1.31, 1.0 is the top bit alone.
    localparam int unsigned ACC_W = 32;
    localparam logic [ACC_W-1:0] ONE_Q31 = 32'h8000_0000;

    // Level format: Q1.15, 1.0 is 32768.
    localparam int unsigned LVL_W = 16;
    localparam int unsigned ENV_LVL_W = 15;
    localparam int unsigned Q15_FRAC = 15;
    localparam logic [LVL_W-1:0] ONE_Q15 = 16'h8000;

    // Shared multiplier operand and product widths.
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 24;
    localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;

    // Configuration port.
    localparam int unsigned COEF_W = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 3'd5;

    localparam logic [COEF_W-1:0] RST_ATTACK = 24'd345909;
    localparam logic [COEF_W-1:0] RST_RELEASE = 24'd17467;
    localparam logic [COEF_W-1:0] RST_DROOP = 24'd13975;
    localparam logic [COEF_W-1:0] RST_RECOVER = 24'd1092;
    localparam logic [LVL_W-1:0] RST_DEPTH = 16'd13763;
    localparam logic [LVL_W-1:0] RST_FLOOR = 16'd9830;

endpackage

`default_nettype wire

// ===== sv/psm_mul.sv =====
`default_nettype none

// Shared unsigned multiplier with a registered product.
module psm_mul (
    input  wire logic                         i_clk,
    input  wire logic [psm_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic [psm_pkg::MUL_B_W-1:0]  i_b,
    output logic      [psm_pkg::PROD_W-1:0]   o_p
);

    logic [psm_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= psm_pkg::PROD_W'(i_a) * psm_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== sv/power_supply_sag_model_unit.sv =====
// A new sample request is accepted only in the idle state, after the previous
// result was loaded into the output register. The single shared 32x24 multiplier is
// used three times per sample (envelope step, sag target, supply step).
// Reset: synchronous, active low; envelope goes to 0, supply to 1.0 and the
// six configuration registers to their default values.
`default_nettype none

module power_supply_sag_model_unit #(
    parameter int unsigned SAMPLE_WIDTH   = 16,
    parameter int unsigned COEF_FRAC_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Sample requests.
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // Fields from bit 0: sample[SAMPLE_WIDTH-1:0], then zero padding.
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // Result requests.
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // Fields from bit 0: supply_level[15:0], envelope_level[30:16], zero bit 31.
    output logic [31:0]                            o_m_tdata,
    // Configuration writes.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [psm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [psm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned AW = psm_pkg::ACC_W;
    localparam int unsigned PW = psm_pkg::PROD_W;
    localparam int unsigned SW = PW + 2;

    // The sequencer walks the three filter phases one step a cycle unless the output stalls.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EDIFF,
        S_EMUL,
        S_EADD,
        S_TMUL,
        S_TGT,
        S_SDIFF,
        S_SMUL,
        S_SADD
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [psm_pkg::COEF_W-1:0] r_attack;
    logic [psm_pkg::COEF_W-1:0] r_release;
    logic [psm_pkg::COEF_W-1:0] r_droop;
    logic [psm_pkg::COEF_W-1:0] r_recover;
    logic [psm_pkg::LVL_W-1:0]  r_depth;
    logic [psm_pkg::LVL_W-1:0]  r_floor;

    // Filter state and per-sample working registers.
    logic [AW-1:0]              r_env;
    logic [AW-1:0]              r_supply;
    logic [AW-1:0]              r_rect;
    logic [AW-1:0]              r_target;
    logic [AW-1:0]              r_diff;
    logic                       r_up;
    logic [psm_pkg::COEF_W-1:0] r_coef;

    logic        r_out_valid;
    logic [31:0] r_out_data;

    // Next values and helpers.
    logic [SAMPLE_WIDTH-1:0]    n_raw;
    logic [SAMPLE_WIDTH-1:0]    n_mag;
    logic [AW-1:0]              n_rect;
    logic [psm_pkg::LVL_W-1:0]  n_depth_c;
    logic [psm_pkg::LVL_W-1:0]  n_floor_c;
    logic [AW-1:0]              n_step;
    logic [PW-1:0]              n_drop_full;
    logic [AW-1:0]              n_drop;
    logic [AW-1:0]              n_sag;
    logic [AW-1:0]              n_floor_q31;
    logic [psm_pkg::ENV_LVL_W-1:0] n_env_lvl;
    logic                       n_load_out;

    logic [psm_pkg::MUL_A_W-1:0] w_mul_a;
    logic [psm_pkg::MUL_B_W-1:0] w_mul_b;
    logic [PW-1:0]               w_prod;

    // One filter step: move acc toward its target by the scaled product, and
    // keep the result inside 0..1.0.
    function automatic logic [AW-1:0] f_step(
        input logic [AW-1:0] acc,
        input logic [PW-1:0] prod,
        input logic          up
    );
        logic [PW-1:0] delta;
        logic [SW-1:0] sum;
        logic [AW-1:0] res;
        delta = prod >> COEF_FRAC_BITS;
        if (up) begin
            sum = SW'(acc) + SW'(delta);
        end else begin
            sum = SW'(acc) - SW'(delta);
        end
        if (sum[SW-1]) begin
            res = '0;
        end else if (sum > SW'(psm_pkg::ONE_Q31)) begin
            res = psm_pkg::ONE_Q31;
        end else begin
            res = sum[AW-1:0];
        end
        return res;
    endfunction

    psm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    always_comb begin
        // Rectifier: two's complement magnitude, the most negative code
        // turns into exactly 1.0, then aligned to Q1.31.
        n_raw = i_s_tdata[SAMPLE_WIDTH-1:0];
        n_mag = n_raw[SAMPLE_WIDTH-1] ? (~n_raw + 1'b1) : n_raw;
        n_rect = {n_mag, {(AW-SAMPLE_WIDTH){1'b0}}};

        // Depth and floor settings above 1.0 count as 1.0.
        n_depth_c = (r_depth > psm_pkg::ONE_Q15) ? psm_pkg::ONE_Q15 : r_depth;
        n_floor_c = (r_floor > psm_pkg::ONE_Q15) ? psm_pkg::ONE_Q15 : r_floor;

        // The multiplier sees the sag product in the target step and the
        // filter difference times its coefficient otherwise.
        if (r_state == S_TMUL) begin
            w_mul_a = r_env;
            w_mul_b = psm_pkg::MUL_B_W'(n_depth_c);
        end else begin
            w_mul_a = r_diff;
            w_mul_b = r_coef;
        end

        n_step = f_step((r_state == S_SADD) ? r_supply : r_env, w_prod, r_up);

        n_drop_full = w_prod >> psm_pkg::Q15_FRAC;
        n_drop = n_drop_full[AW-1:0];
        n_sag = psm_pkg::ONE_Q31 - n_drop;
        n_floor_q31 = {n_floor_c, {(AW-psm_pkg::LVL_W){1'b0}}};

        // Envelope level is reported with full scale pulled down by one code.
        n_env_lvl = n_step[AW-1] ? {psm_pkg::ENV_LVL_W{1'b1}}
                                 : n_step[AW-2 -: psm_pkg::ENV_LVL_W];
        n_env_lvl = (r_state == S_SADD)
                  ? (r_env[AW-1] ? {psm_pkg::ENV_LVL_W{1'b1}}
                                 : r_env[AW-2 -: psm_pkg::ENV_LVL_W])
                  : n_env_lvl;

        n_load_out = (r_state == S_SADD) && (!r_out_valid || i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_attack    <= psm_pkg::RST_ATTACK;
            r_release   <= psm_pkg::RST_RELEASE;
            r_droop     <= psm_pkg::RST_DROOP;
            r_recover   <= psm_pkg::RST_RECOVER;
            r_depth     <= psm_pkg::RST_DEPTH;
            r_floor     <= psm_pkg::RST_FLOOR;
            r_env       <= '0;
            r_supply    <= psm_pkg::ONE_Q31;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes land at once; the user must only write while idle (not enforced).
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    psm_pkg::CFG_ATTACK:  r_attack  <= i_cfg_data;
                    psm_pkg::CFG_RELEASE: r_release <= i_cfg_data;
                    psm_pkg::CFG_DROOP:   r_droop   <= i_cfg_data;
                    psm_pkg::CFG_RECOVER: r_recover <= i_cfg_data;
                    psm_pkg::CFG_DEPTH:   r_depth   <= i_cfg_data[psm_pkg::LVL_W-1:0];
                    psm_pkg::CFG_FLOOR:   r_floor   <= i_cfg_data[psm_pkg::LVL_W-1:0];
                    default: ;
                endcase
            end

            // A result taken in the same cycle as a new one is loaded stays valid.
            if (r_out_valid && i_m_tready && !n_load_out) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_rect  <= n_rect;
                        r_state <= S_EDIFF;
                    end
                end
                S_EDIFF: begin
                    // Attack only when the rectified sample is strictly above.
                    r_up    <= (r_rect >= r_env);
                    r_diff  <= (r_rect >= r_env) ? (r_rect - r_env) : (r_env - r_rect);
                    r_coef  <= (r_rect > r_env) ? r_attack : r_release;
                    r_state <= S_EMUL;
                end
                S_EMUL: begin
                    r_state <= S_EADD;
                end
                S_EADD: begin
                    r_env   <= n_step;
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_state <= S_TGT;
                end
                S_TGT: begin
                    r_target <= (n_sag < n_floor_q31) ? n_floor_q31 : n_sag;
                    r_state  <= S_SDIFF;
                end
                S_SDIFF: begin
                    // Droop only when the target is strictly below the supply.
                    r_up    <= (r_target >= r_supply);
                    r_diff  <= (r_target >= r_supply) ? (r_target - r_supply)
                                                      : (r_supply - r_target);
                    r_coef  <= (r_target < r_supply) ? r_droop : r_recover;
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_state <= S_SADD;
                end
                S_SADD: begin
                    // Hold here until the output register is free.
                    if (n_load_out) begin
                        r_supply    <= n_step;
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, n_env_lvl,
                                        n_step[AW-1 -: psm_pkg::LVL_W]};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // A sample in work blocks the next request until its result is out.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("sample accepted while the previous one is in work");

    // Both accumulators stay within 0..1.0.
    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= psm_pkg::ONE_Q31)
        else $error("envelope accumulator above 1.0");

    a_supply_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_supply <= psm_pkg::ONE_Q31)
        else $error("supply accumulator above 1.0");

    // A new result only appears at the end of the supply step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_SADD))
        else $error("result raised outside the supply step");
`endif

endmodule

`default_nettype wire

// ===== verif/power_supply_sag_model_unit_test.sv =====
`timescale 1ns / 1ps

module power_supply_sag_model_unit_test;

    // Width of one sample and of the coefficient fraction at this build.
    localparam int SAMPLE_W = 16;
    localparam int COEF_FRAC = 24;

    // Settling wait before a register write, once nothing is owed.
    localparam int SETTLE = 16;

    // Random items per full configuration phase; shorter phases take half.
    localparam int PHASE_ITEMS = 270;

    // The result side holds off once for a long stretch, after this many
    // sample requests went in, so that the block backs up into its input.
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_CYCLES = 400;

    // Cycles in a row with no request moving on any channel before we give up.
    localparam int IDLE_LIMIT = 3000;

    // Register indexes past the end of the list; writes to them do nothing.
    localparam logic [psm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [psm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Opening samples: silence first, so that the rectified sample equals the
    // empty envelope and the target equals the full supply, then the two
    // full-scale values, the most negative one held so the envelope climbs,
    // the smallest magnitudes, and patterns that toggle every bit.
    localparam logic [0:15][15:0] CORNER_SAMPLES = '{
        16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001,
        16'h8001, 16'h7FFE, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'h0100, 16'hFF00
    };

    // Shapes of the random program material. A segment of one shape runs for
    // 4 to 60 samples, so loud passages pull the supply down toward its
    // floor and quiet ones let it recover.
    typedef enum int {
        SHAPE_QUIET,
        SHAPE_NOISE,
        SHAPE_LOUD,
        SHAPE_HOLD,
        SHAPE_TONE,
        SHAPE_CORNER
    } t_signal_shape;

    // The two levels of one result, as separate fields.
    typedef struct packed {
        logic [psm_pkg::LVL_W-1:0]     supply;
        logic [psm_pkg::ENV_LVL_W-1:0] envelope;
    } t_sag_levels;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           s_tvalid = 1'b0;
    logic [SAMPLE_W-1:0]            s_tdata = '0;
    logic                           m_tready = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [psm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [psm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    wire        s_tready;
    wire        m_tvalid;
    wire [31:0] m_tdata;
    wire        cfg_ready;

    // Our own copy of the six registers, at their reset values.
    logic [psm_pkg::COEF_W-1:0] attack_k = psm_pkg::RST_ATTACK;
    logic [psm_pkg::COEF_W-1:0] release_k = psm_pkg::RST_RELEASE;
    logic [psm_pkg::COEF_W-1:0] droop_k = psm_pkg::RST_DROOP;
    logic [psm_pkg::COEF_W-1:0] recover_k = psm_pkg::RST_RECOVER;
    logic [psm_pkg::LVL_W-1:0]  depth_q15 = psm_pkg::RST_DEPTH;
    logic [psm_pkg::LVL_W-1:0]  floor_q15 = psm_pkg::RST_FLOOR;

    // Our own copy of the two accumulators, Q1.31.
    logic [psm_pkg::ACC_W-1:0] env_acc = '0;
    logic [psm_pkg::ACC_W-1:0] sup_acc = psm_pkg::ONE_Q31;

    logic [SAMPLE_W-1:0] sample_backlog [$];
    t_sag_levels         levels_due [$];

    int  samples_taken = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  steady = 1'b0;
    bit  hold_off = 1'b0;

    power_supply_sag_model_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // One step of a one-pole follower: move the accumulator toward the goal
    // by the distance times the coefficient, truncated in magnitude. With a
    // 24-bit fraction the step never overshoots, so no clamping is needed.
    function automatic logic [psm_pkg::ACC_W-1:0] glide(
        input logic [psm_pkg::ACC_W-1:0]  acc,
        input logic [psm_pkg::ACC_W-1:0]  goal,
        input logic [psm_pkg::COEF_W-1:0] coef);
        logic [63:0] step;
        if (goal >= acc) begin
            step = (64'(goal - acc) * 64'(coef)) >> COEF_FRAC;
            return acc + step[psm_pkg::ACC_W-1:0];
        end else begin
            step = (64'(acc - goal) * 64'(coef)) >> COEF_FRAC;
            return acc - step[psm_pkg::ACC_W-1:0];
        end
    endfunction

    // Advances the envelope and the supply by one sample and returns the
    // levels that the block must report for it.
    function automatic t_sag_levels advance_sag(input logic [SAMPLE_W-1:0] sample);
        logic [SAMPLE_W-1:0]       mag;
        logic [psm_pkg::ACC_W-1:0] rect;
        logic [psm_pkg::ACC_W-1:0] goal;
        logic [psm_pkg::ACC_W-1:0] floor_lvl;
        logic [psm_pkg::LVL_W-1:0] depth_eff;
        logic [psm_pkg::LVL_W-1:0] floor_eff;
        logic [63:0]               drop;
        t_sag_levels               lv;
        // The magnitude of the most negative sample is exactly 1.0.
        mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
        rect = {mag, 16'h0000};
        // A tie between sample and envelope takes the release path.
        env_acc = glide(env_acc, rect, (rect > env_acc) ? attack_k : release_k);

        // Depth and floor above one count as one.
        depth_eff = (depth_q15 > psm_pkg::ONE_Q15) ? psm_pkg::ONE_Q15 : depth_q15;
        floor_eff = (floor_q15 > psm_pkg::ONE_Q15) ? psm_pkg::ONE_Q15 : floor_q15;
        drop = (64'(depth_eff) * 64'(env_acc)) >> psm_pkg::Q15_FRAC;
        goal = psm_pkg::ONE_Q31 - drop[psm_pkg::ACC_W-1:0];
        floor_lvl = {floor_eff, 16'h0000};
        if (goal < floor_lvl) begin
            goal = floor_lvl;
        end
        // A tie between target and supply takes the recover path.
        sup_acc = glide(sup_acc, goal, (goal < sup_acc) ? droop_k : recover_k);

        lv.supply = sup_acc[31:16];
        // The envelope level is only 15 bits wide; a full-scale envelope pins it.
        lv.envelope = env_acc[31] ? 15'h7FFF : env_acc[30:16];
        return lv;
    endfunction

    // Mirrors a register write; indexes past the list leave everything alone.
    function automatic void apply_setting(input logic [psm_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [psm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            psm_pkg::CFG_ATTACK: attack_k = data[psm_pkg::COEF_W-1:0];
            psm_pkg::CFG_RELEASE: release_k = data[psm_pkg::COEF_W-1:0];
            psm_pkg::CFG_DROOP: droop_k = data[psm_pkg::COEF_W-1:0];
            psm_pkg::CFG_RECOVER: recover_k = data[psm_pkg::COEF_W-1:0];
            psm_pkg::CFG_DEPTH: depth_q15 = data[psm_pkg::LVL_W-1:0];
            psm_pkg::CFG_FLOOR: floor_q15 = data[psm_pkg::LVL_W-1:0];
            default: ;
        endcase
    endfunction

    // Idle gap after a request: mostly none, sometimes a few cycles, rarely
    // a long one. In steady phases neither side idles at all.
    function automatic int pick_gap();
        int roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("result %0d, %s: expected 0x%0h, got 0x%0h",
                 results_seen, field, want, got);
    endtask

    // Writes one register over the configuration channel and mirrors it once
    // the request is taken. It starts and ends right after a rising edge.
    task automatic write_setting(input logic [psm_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [psm_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        apply_setting(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Queues random program material made of segments of varied shape.
    task automatic queue_program(input int count);
        int            seg_len;
        int            level;
        int            mag;
        logic [15:0]   held;
        logic [15:0]   s;
        t_signal_shape shape;
        while (count > 0) begin
            seg_len = $urandom_range(4, 60);
            if (seg_len > count) begin
                seg_len = count;
            end
            shape = t_signal_shape'($urandom_range(0, 5));
            level = $urandom_range(1, 32768);
            held = 16'($urandom);
            for (int i = 0; i < seg_len; i++) begin
                case (shape)
                    SHAPE_QUIET: s = 16'($urandom_range(0, 15)) - 16'd8;
                    SHAPE_NOISE: s = 16'($urandom);
                    SHAPE_LOUD: begin
                        mag = $urandom_range(24576, 32768);
                        s = $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
                    end
                    SHAPE_HOLD: s = held;
                    SHAPE_TONE: s = (i % 2) ? 16'(level) : 16'(-level);
                    default: s = CORNER_SAMPLES[$urandom_range(0, 15)];
                endcase
                sample_backlog.push_back(s);
            end
            count -= seg_len;
        end
    endtask

    // Waits until every queued sample went in and every result came back,
    // then lets the pipeline settle. Returns right after a rising edge.
    task automatic wait_quiet();
        do begin
            @(negedge clk);
        end while (sample_backlog.size() != 0 || s_tvalid || levels_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes all six registers with random values. With raw set the whole
    // 24-bit word is random, so depth and floor see their upper bits too and
    // often land above one.
    task automatic randomize_settings(input bit raw);
        for (int idx = psm_pkg::CFG_ATTACK; idx <= psm_pkg::CFG_FLOOR; idx++) begin
            if (raw) begin
                write_setting(psm_pkg::CFG_IDX_W'(idx), psm_pkg::CFG_DATA_W'($urandom));
            end else if (idx < psm_pkg::CFG_DEPTH) begin
                write_setting(psm_pkg::CFG_IDX_W'(idx),
                              psm_pkg::CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
            end else begin
                write_setting(psm_pkg::CFG_IDX_W'(idx),
                              psm_pkg::CFG_DATA_W'($urandom_range(0, 32768)));
            end
        end
    endtask

    // Sample driver. On every accepted sample request the predictor runs
    // and the expected levels join the queue. A new request is offered only
    // once the previous one was taken, so a raised valid is never withdrawn.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                levels_due.push_back(advance_sag(s_tdata));
                samples_taken++;
                send_wait = pick_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (sample_backlog.size() > 0) begin
                    s_tdata <= sample_backlog.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each accepted result request is checked field by field
    // against the oldest expectation; ready drops for random gaps and for the
    // one long hold-off.
    always @(posedge clk) begin
        t_sag_levels want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (levels_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_tdata);
                end else begin
                    want = levels_due.pop_front();
                    if (m_tdata[15:0] !== want.supply) begin
                        report_mismatch("supply_level", 32'(want.supply), 32'(m_tdata[15:0]));
                    end
                    if (m_tdata[30:16] !== want.envelope) begin
                        report_mismatch("envelope_level", 32'(want.envelope),
                                        32'(m_tdata[30:16]));
                    end
                    if (m_tdata[31] !== 1'b0) begin
                        report_mismatch("padding bit", '0, 32'(m_tdata[31]));
                    end
                end
                recv_wait = pick_gap();
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !hold_off;
            end
        end
    end

    // The long hold-off on the result side, counted here in clock cycles.
    // The sender keeps offering samples all the while.
    initial begin
        wait (samples_taken >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: a run of cycles with no request moving anywhere ends the test.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("no request moved for %0d cycles, %0d results still owed",
                     IDLE_LIMIT, levels_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus sequence: reset, then phases of samples under different
    // register settings, each setting written while the block is idle.
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: the directed corners, then program material.
        @(negedge clk);
        for (int k = 0; k < 16; k++) begin
            sample_backlog.push_back(CORNER_SAMPLES[k]);
        end
        queue_program(PHASE_ITEMS);
        wait_quiet();

        // Fastest filters, full depth and no floor: the supply can sink to zero.
        write_setting(psm_pkg::CFG_ATTACK, 24'hFFFFFF);
        write_setting(psm_pkg::CFG_RELEASE, 24'hFFFFFF);
        write_setting(psm_pkg::CFG_DROOP, 24'hFFFFFF);
        write_setting(psm_pkg::CFG_RECOVER, 24'hFFFFFF);
        write_setting(psm_pkg::CFG_DEPTH, 24'(psm_pkg::ONE_Q15));
        write_setting(psm_pkg::CFG_FLOOR, 24'h000000);
        @(negedge clk);
        steady = 1'b1;
        for (int k = 0; k < 16; k++) begin
            sample_backlog.push_back(CORNER_SAMPLES[k]);
        end
        queue_program(PHASE_ITEMS);
        wait_quiet();

        // Frozen filters, no depth, floor at one; writes past the register
        // list must leave all of this unchanged.
        write_setting(psm_pkg::CFG_ATTACK, 24'h000000);
        write_setting(psm_pkg::CFG_RELEASE, 24'h000000);
        write_setting(psm_pkg::CFG_DROOP, 24'h000000);
        write_setting(psm_pkg::CFG_RECOVER, 24'h000000);
        write_setting(psm_pkg::CFG_DEPTH, 24'h000000);
        write_setting(psm_pkg::CFG_FLOOR, 24'(psm_pkg::ONE_Q15));
        write_setting(CFG_SPARE_LO, psm_pkg::CFG_DATA_W'($urandom));
        write_setting(CFG_SPARE_HI, psm_pkg::CFG_DATA_W'($urandom));
        @(negedge clk);
        steady = 1'b0;
        queue_program(PHASE_ITEMS / 2);
        wait_quiet();

        // Depth and floor above one, in turn, under random coefficients.
        randomize_settings(1'b0);
        write_setting(psm_pkg::CFG_DEPTH, 24'h00FFFF);
        write_setting(psm_pkg::CFG_FLOOR, 24'h000000);
        @(negedge clk);
        queue_program(PHASE_ITEMS / 2);
        wait_quiet();
        write_setting(psm_pkg::CFG_DEPTH, 24'(psm_pkg::ONE_Q15));
        write_setting(psm_pkg::CFG_FLOOR, 24'h00A000);
        @(negedge clk);
        queue_program(PHASE_ITEMS / 2);
        wait_quiet();

        // Random settings within range, no idling.
        randomize_settings(1'b0);
        @(negedge clk);
        steady = 1'b1;
        queue_program(PHASE_ITEMS);
        wait_quiet();

        // Random raw words on every register.
        randomize_settings(1'b1);
        @(negedge clk);
        steady = 1'b0;
        queue_program(PHASE_ITEMS);
        wait_quiet();

        // Quick envelope, deep sag, low floor: the supply swings hard.
        write_setting(psm_pkg::CFG_ATTACK,
                      psm_pkg::CFG_DATA_W'($urandom_range(24'h400000, 24'hFFFFFF)));
        write_setting(psm_pkg::CFG_RELEASE,
                      psm_pkg::CFG_DATA_W'($urandom_range(24'h010000, 24'h400000)));
        write_setting(psm_pkg::CFG_DROOP,
                      psm_pkg::CFG_DATA_W'($urandom_range(24'h010000, 24'h800000)));
        write_setting(psm_pkg::CFG_RECOVER,
                      psm_pkg::CFG_DATA_W'($urandom_range(24'h001000, 24'h100000)));
        write_setting(psm_pkg::CFG_DEPTH, psm_pkg::CFG_DATA_W'($urandom_range(24576, 32768)));
        write_setting(psm_pkg::CFG_FLOOR, psm_pkg::CFG_DATA_W'($urandom_range(0, 8192)));
        @(negedge clk);
        queue_program(PHASE_ITEMS);
        wait_quiet();

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
